### design/pst_pkg.sv
// Package for the path selector tokenizer: sizes, character codes, result kinds
// and the state encodings. No dependencies.
`default_nettype none
package pst_pkg;

    localparam int SEG_LEN = 32;
    localparam int ADDR_W  = $clog2(SEG_LEN);
    localparam int LEN_W   = $clog2(SEG_LEN + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_DOT     = 3'b010,
        MODE_BRACKET = 3'b100
    } mode_t;

    typedef enum logic [4:0] {
        ST_IN  = 5'b00001,
        ST_RD  = 5'b00010,
        ST_KEY = 5'b00100,
        ST_IDX = 5'b01000,
        ST_END = 5'b10000
    } state_t;

endpackage
`default_nettype wire

### design/path_selector_tokenizer_unit.sv
// Path selector tokenizer top level: segment buffer memory, incremental trim and
// index tracking, and the result sequencer. Depends on pst_pkg.
// A character that only extends a segment or changes mode does not hold the input.
// A character that closes a segment holds the input for the results it causes:
// an index result or end marker is loaded into the output register, and each key
// character needs a segment-memory read and then the load of the output register.
// The output register lets the last result wait while the next characters are taken.
`default_nettype none
module path_selector_tokenizer_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // [7:0] key_char, [39:8] index_value, [40] truncated
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    localparam int LW = pst_pkg::LEN_W;
    localparam int AW = pst_pkg::ADDR_W;

    // segment buffer
    logic [7:0] seg_mem [pst_pkg::SEG_LEN];
    logic [7:0] rdata_reg;
    logic       mem_we;

    pst_pkg::state_t state_reg, state_next;
    pst_pkg::mode_t  mode_reg, mode_next;

    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic          has_ns_reg, has_ns_next;
    logic          pend_sp_reg, pend_sp_next;
    logic          all_ok_reg, all_ok_next;
    logic          act_reg, act_next;
    logic          neg_reg, neg_next;
    logic [31:0]   val_reg, val_next;
    logic [LW-1:0] b_reg, b_next;
    logic [LW-1:0] e_reg, e_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    lastc_reg, lastc_next;

    logic [LW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] stop_reg, stop_next;
    logic          endp_reg, endp_next;
    logic          trunc_reg, trunc_next;
    logic [31:0]   idx_reg, idx_next;

    logic          ov_reg, ov_next;
    logic [1:0]    okind_reg, okind_next;
    logic [7:0]    okey_reg, okey_next;
    logic [31:0]   oidx_reg, oidx_next;
    logic          otr_reg, otr_next;
    logic          olast_reg, olast_next;

    logic [7:0]    c;
    logic          fire, out_free;
    logic          flush_dot, flush_br, do_append, do_start;
    logic          is_sp, is_dig, quoted;
    logic [LW-1:0] key_b, key_e, ptr_inc;
    logic          emit_keys, emit_idx;

    assign c        = s_tdata;
    assign s_tready = (state_reg == pst_pkg::ST_IN);
    assign fire     = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, otr_reg, oidx_reg, okey_reg};

    assign is_sp  = (c == pst_pkg::CH_SPACE) || (c >= pst_pkg::CH_TAB && c <= pst_pkg::CH_CR);
    assign is_dig = (c >= pst_pkg::CH_ZERO) && (c <= pst_pkg::CH_NINE);

    assign flush_dot = (mode_reg == pst_pkg::MODE_DOT) &&
                       (c == pst_pkg::CH_DOT || c == pst_pkg::CH_LBR || c == pst_pkg::CH_NUL);
    assign flush_br  = (mode_reg == pst_pkg::MODE_BRACKET) && (c == pst_pkg::CH_RBR);
    assign do_append = ((mode_reg == pst_pkg::MODE_DOT) && !flush_dot) ||
                       ((mode_reg == pst_pkg::MODE_BRACKET) &&
                        c != pst_pkg::CH_RBR && c != pst_pkg::CH_NUL);
    assign do_start  = flush_dot || flush_br || (c == pst_pkg::CH_NUL) ||
                       ((mode_reg == pst_pkg::MODE_IDLE) &&
                        (c == pst_pkg::CH_DOT || c == pst_pkg::CH_LBR));

    assign quoted = (first_reg == lastc_reg) &&
                    (first_reg == pst_pkg::CH_DQ || first_reg == pst_pkg::CH_SQ);
    assign key_b  = (flush_br && quoted) ? b_reg + LW'(1) : b_reg;
    assign key_e  = (flush_br && quoted) ? e_reg - LW'(1) : e_reg;
    assign emit_idx  = flush_br && has_ns_reg && all_ok_reg;
    assign emit_keys = has_ns_reg && (flush_dot || (flush_br && !all_ok_reg)) &&
                       (key_b < key_e);
    assign ptr_inc   = ptr_reg + LW'(1);

    assign mem_we = fire && do_append && (len_reg < LW'(pst_pkg::SEG_LEN));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seg_mem[len_reg[AW-1:0]] <= c;
        end
        if (state_reg == pst_pkg::ST_RD) begin
            rdata_reg <= seg_mem[ptr_reg[AW-1:0]];
        end
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        has_ns_next  = has_ns_reg;
        pend_sp_next = pend_sp_reg;
        all_ok_next  = all_ok_reg;
        act_next     = act_reg;
        neg_next     = neg_reg;
        val_next     = val_reg;
        b_next       = b_reg;
        e_next       = e_reg;
        first_next   = first_reg;
        lastc_next   = lastc_reg;
        ptr_next     = ptr_reg;
        stop_next    = stop_reg;
        endp_next    = endp_reg;
        trunc_next   = trunc_reg;
        idx_next     = idx_reg;
        ov_next      = ov_reg && !m_tready;
        okind_next   = okind_reg;
        okey_next    = okey_reg;
        oidx_next    = oidx_reg;
        otr_next     = otr_reg;
        olast_next   = olast_reg;

        case (state_reg)
            pst_pkg::ST_IN: begin
                if (fire) begin
                    if (do_append) begin
                        if (len_reg < LW'(pst_pkg::SEG_LEN)) begin
                            len_next = len_reg + LW'(1);
                            if (!is_sp) begin
                                if (!has_ns_reg) begin
                                    has_ns_next = 1'b1;
                                    b_next      = len_reg;
                                    first_next  = c;
                                    neg_next    = (c == pst_pkg::CH_MINUS);
                                    act_next    = (c == pst_pkg::CH_MINUS) || is_dig;
                                    val_next    = is_dig ? {28'd0, c[3:0]} : 32'd0;
                                end else if (pend_sp_reg) begin
                                    act_next = 1'b0;
                                end else if (act_reg) begin
                                    if (is_dig) begin
                                        val_next = (val_reg << 3) + (val_reg << 1) +
                                                   {28'd0, c[3:0]};
                                    end else begin
                                        act_next = 1'b0;
                                    end
                                end
                                all_ok_next  = all_ok_reg && (is_dig || c == pst_pkg::CH_MINUS)
                                               && !(has_ns_reg && pend_sp_reg);
                                e_next       = len_reg + LW'(1);
                                lastc_next   = c;
                                pend_sp_next = 1'b0;
                            end else if (has_ns_reg) begin
                                pend_sp_next = 1'b1;
                            end
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (do_start) begin
                        ptr_next   = key_b;
                        stop_next  = key_e;
                        endp_next  = (c == pst_pkg::CH_NUL);
                        trunc_next = ovf_reg;
                        idx_next   = neg_reg ? 32'd0 - val_reg : val_reg;
                        if (emit_keys) begin
                            state_next = pst_pkg::ST_RD;
                        end else if (emit_idx) begin
                            state_next = pst_pkg::ST_IDX;
                        end else if (c == pst_pkg::CH_NUL) begin
                            state_next = pst_pkg::ST_END;
                        end
                        len_next     = '0;
                        ovf_next     = 1'b0;
                        has_ns_next  = 1'b0;
                        pend_sp_next = 1'b0;
                        all_ok_next  = 1'b1;
                        act_next     = 1'b0;
                        neg_next     = 1'b0;
                        val_next     = 32'd0;
                        if (c == pst_pkg::CH_NUL || flush_br) begin
                            mode_next = pst_pkg::MODE_IDLE;
                        end else if (c == pst_pkg::CH_DOT) begin
                            mode_next = pst_pkg::MODE_DOT;
                        end else begin
                            mode_next = pst_pkg::MODE_BRACKET;
                        end
                    end
                end
            end
            pst_pkg::ST_RD: begin
                state_next = pst_pkg::ST_KEY;
            end
            pst_pkg::ST_KEY: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = pst_pkg::KIND_KEY;
                    okey_next  = rdata_reg;
                    oidx_next  = 32'd0;
                    otr_next   = trunc_reg;
                    olast_next = (ptr_inc == stop_reg) && !endp_reg;
                    ptr_next   = ptr_inc;
                    if (ptr_inc != stop_reg) begin
                        state_next = pst_pkg::ST_RD;
                    end else if (endp_reg) begin
                        state_next = pst_pkg::ST_END;
                    end else begin
                        state_next = pst_pkg::ST_IN;
                    end
                end
            end
            pst_pkg::ST_IDX: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = pst_pkg::KIND_INDEX;
                    okey_next  = 8'd0;
                    oidx_next  = idx_reg;
                    otr_next   = trunc_reg;
                    olast_next = !endp_reg;
                    state_next = endp_reg ? pst_pkg::ST_END : pst_pkg::ST_IN;
                end
            end
            pst_pkg::ST_END: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = pst_pkg::KIND_END;
                    okey_next  = 8'd0;
                    oidx_next  = 32'd0;
                    otr_next   = 1'b0;
                    olast_next = 1'b1;
                    state_next = pst_pkg::ST_IN;
                end
            end
            default: begin
                state_next = pst_pkg::ST_IN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pst_pkg::ST_IN;
            mode_reg    <= pst_pkg::MODE_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            has_ns_reg  <= 1'b0;
            pend_sp_reg <= 1'b0;
            all_ok_reg  <= 1'b1;
            act_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            val_reg     <= 32'd0;
            ov_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            has_ns_reg  <= has_ns_next;
            pend_sp_reg <= pend_sp_next;
            all_ok_reg  <= all_ok_next;
            act_reg     <= act_next;
            neg_reg     <= neg_next;
            val_reg     <= val_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg     <= b_next;
        e_reg     <= e_next;
        first_reg <= first_next;
        lastc_reg <= lastc_next;
        ptr_reg   <= ptr_next;
        stop_reg  <= stop_next;
        endp_reg  <= endp_next;
        trunc_reg <= trunc_next;
        idx_reg   <= idx_next;
        okind_reg <= okind_next;
        okey_reg  <= okey_next;
        oidx_reg  <= oidx_next;
        otr_reg   <= otr_next;
        olast_reg <= olast_next;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(pst_pkg::SEG_LEN))
        else $error("segment length past buffer size");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> len_reg == LW'(pst_pkg::SEG_LEN))
        else $error("overflow flagged with room left");

    a_nul_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && c == pst_pkg::CH_NUL |=> len_reg == '0 && mode_reg == pst_pkg::MODE_IDLE)
        else $error("selector end did not clear the segment");

    a_read_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pst_pkg::ST_RD |-> ptr_reg < stop_reg && ptr_reg < LW'(pst_pkg::SEG_LEN))
        else $error("key read outside the kept segment");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && okind_reg == pst_pkg::KIND_END |-> olast_reg && !otr_reg)
        else $error("end marker without last");

endmodule
`default_nettype wire

### dv/path_selector_tokenizer_unit_tb.sv
// Self-checking testbench for path_selector_tokenizer_unit: a scoreboard class predicts
// the key, index and end results of each character; tasks drive bursty stimulus.
// Depends on pst_pkg and the design top level.
module path_selector_tokenizer_unit_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int CHAR_TARGET = 305;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  key_char;
        logic [31:0] index_value;
        logic        truncated;
        logic        last;
    } token_t;

    class token_scoreboard;
        pst_pkg::mode_t mode;
        logic [7:0]     seg_buf [pst_pkg::SEG_LEN];
        int             seg_len;
        bit             seg_ovf;
        token_t         token_q [$];
        token_t         held;
        bit             held_ok;
        int             errors, n_chars, n_busy, n_keys, n_idx, n_end, n_trunc;

        function new();
            mode = pst_pkg::MODE_IDLE;
        endfunction

        static function bit is_ws(logic [7:0] c);
            return c == pst_pkg::CH_SPACE || (c >= pst_pkg::CH_TAB && c <= pst_pkg::CH_CR);
        endfunction

        static function bit is_num(logic [7:0] c);
            return c >= pst_pkg::CH_ZERO && c <= pst_pkg::CH_NINE;
        endfunction

        function void add_token(token_t t);
            token_q.insert(token_q.size(), t);
        endfunction

        // the newest token is held back so that the last one of a character can be marked
        function void emit(logic [1:0] kind, logic [7:0] key, logic [31:0] idx, bit tr);
            if (held_ok)
                add_token(held);
            held.kind        = kind;
            held.key_char    = key;
            held.index_value = idx;
            held.truncated   = tr;
            held.last        = 1'b0;
            held_ok          = 1'b1;
        endfunction

        function void restart();
            seg_len = 0;
            seg_ovf = 1'b0;
        endfunction

        function void store(logic [7:0] c);
            if (seg_len < pst_pkg::SEG_LEN) begin
                seg_buf[seg_len] = c;
                seg_len++;
            end else begin
                seg_ovf = 1'b1;
            end
        endfunction

        function void close_segment(bit key_only);
            int          b, e, i;
            bit          all_num, neg;
            logic [31:0] v;
            b = 0;
            e = seg_len;
            while (b < e && is_ws(seg_buf[b]))
                b++;
            while (e > b && is_ws(seg_buf[e-1]))
                e--;
            if (b >= e)
                return;
            if (!key_only) begin
                all_num = 1'b1;
                for (i = b; i < e; i++)
                    if (!(seg_buf[i] == pst_pkg::CH_MINUS || is_num(seg_buf[i])))
                        all_num = 1'b0;
                if (all_num) begin
                    v = '0;
                    neg = 1'b0;
                    i = b;
                    if (seg_buf[i] == pst_pkg::CH_MINUS) begin
                        neg = 1'b1;
                        i++;
                    end
                    while (i < e && is_num(seg_buf[i])) begin
                        v = v * 32'd10 + 32'(seg_buf[i] - pst_pkg::CH_ZERO);
                        i++;
                    end
                    if (neg)
                        v = 32'd0 - v;
                    emit(pst_pkg::KIND_INDEX, 8'h00, v, seg_ovf);
                    return;
                end
                if ((seg_buf[b] == pst_pkg::CH_DQ && seg_buf[e-1] == pst_pkg::CH_DQ) ||
                    (seg_buf[b] == pst_pkg::CH_SQ && seg_buf[e-1] == pst_pkg::CH_SQ)) begin
                    if (e - b < 2)
                        return;
                    b++;
                    e--;
                end
            end
            for (i = b; i < e; i++)
                emit(pst_pkg::KIND_KEY, seg_buf[i], 32'd0, seg_ovf);
        endfunction

        // returns 1 when the character is not simply ignored
        function bit take_char(logic [7:0] c);
            bit busy;
            busy = mode != pst_pkg::MODE_IDLE || c == pst_pkg::CH_DOT ||
                   c == pst_pkg::CH_LBR || c == pst_pkg::CH_NUL;
            n_chars++;
            if (busy)
                n_busy++;
            case (mode)
                pst_pkg::MODE_DOT: begin
                    if (c == pst_pkg::CH_DOT || c == pst_pkg::CH_LBR || c == pst_pkg::CH_NUL) begin
                        close_segment(1'b1);
                        restart();
                        if (c == pst_pkg::CH_DOT)
                            mode = pst_pkg::MODE_DOT;
                        else if (c == pst_pkg::CH_LBR)
                            mode = pst_pkg::MODE_BRACKET;
                        else
                            mode = pst_pkg::MODE_IDLE;
                    end else begin
                        store(c);
                    end
                end
                pst_pkg::MODE_BRACKET: begin
                    if (c == pst_pkg::CH_RBR) begin
                        close_segment(1'b0);
                        restart();
                        mode = pst_pkg::MODE_IDLE;
                    end else if (c == pst_pkg::CH_NUL) begin
                        restart();
                        mode = pst_pkg::MODE_IDLE;
                    end else begin
                        store(c);
                    end
                end
                default: begin
                    mode = pst_pkg::MODE_IDLE;
                    if (c == pst_pkg::CH_DOT) begin
                        restart();
                        mode = pst_pkg::MODE_DOT;
                    end else if (c == pst_pkg::CH_LBR) begin
                        restart();
                        mode = pst_pkg::MODE_BRACKET;
                    end
                end
            endcase
            if (c == pst_pkg::CH_NUL) begin
                restart();
                mode = pst_pkg::MODE_IDLE;
                emit(pst_pkg::KIND_END, 8'h00, 32'd0, 1'b0);
            end
            if (held_ok) begin
                held.last = 1'b1;
                add_token(held);
                held_ok = 1'b0;
            end
            return busy;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("mismatch: %s", msg);
        endtask

        task check_token(logic [1:0] kind, logic [47:0] data, logic last);
            token_t w;
            if (token_q.size() == 0) begin
                report($sformatf("unexpected item kind %0d data %h last %b", kind, data, last));
                return;
            end
            w = token_q.pop_front();
            case (w.kind)
                pst_pkg::KIND_KEY:   n_keys++;
                pst_pkg::KIND_INDEX: n_idx++;
                default:             n_end++;
            endcase
            if (w.truncated)
                n_trunc++;
            if (kind !== w.kind)
                report($sformatf("kind %0d, expected %0d", kind, w.kind));
            if (data[7:0] !== w.key_char)
                report($sformatf("key_char %h, expected %h", data[7:0], w.key_char));
            if (data[39:8] !== w.index_value)
                report($sformatf("index_value %0d, expected %0d",
                                 $signed(data[39:8]), $signed(w.index_value)));
            if (data[40] !== w.truncated)
                report($sformatf("truncated %b, expected %b", data[40], w.truncated));
            if (data[47:41] !== 7'd0)
                report($sformatf("padding bits %h not zero", data[47:41]));
            if (last !== w.last)
                report($sformatf("tlast %b, expected %b", last, w.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard sb;
    logic [7:0]      sel_q [$];
    int              burst_left = 0;
    int              cycles = 0;
    int              rdy_cyc = 0;
    int              rdy_style = 0;

    path_selector_tokenizer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycles, sb.token_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern, in one of four styles picked at random
    always @(negedge aclk) begin
        rdy_cyc++;
        if (rdy_cyc % 50 == 0)
            rdy_style = $urandom_range(0, 3);
        case (rdy_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rdy_cyc % 8) < 4;
        endcase
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_token(m_tuser, m_tdata, m_tlast);

    function automatic void put_sel(input logic [7:0] c);
        sel_q.insert(sel_q.size(), c);
    endfunction

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        void'(sb.take_char(c));
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.token_q.size() != 0)
            @(negedge aclk);
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(28, 45) : $urandom_range(0, 6);
    endfunction

    function automatic logic [7:0] seg_char(bit bracket);
        logic [7:0] c;
        do begin
            case ($urandom_range(0, 5))
                0:       c = $urandom_range(0, 1) ? pst_pkg::CH_SPACE :
                             8'($urandom_range(pst_pkg::CH_TAB, pst_pkg::CH_CR));
                1:       c = 8'($urandom_range(pst_pkg::CH_ZERO, pst_pkg::CH_NINE));
                2:       c = $urandom_range(0, 1) ? pst_pkg::CH_MINUS :
                             ($urandom_range(0, 1) ? pst_pkg::CH_DQ : pst_pkg::CH_SQ);
                default: c = 8'($urandom_range(1, 255));
            endcase
        end while (c == pst_pkg::CH_NUL ||
                   (bracket ? c == pst_pkg::CH_RBR :
                              (c == pst_pkg::CH_DOT || c == pst_pkg::CH_LBR)));
        return c;
    endfunction

    task automatic build_selector();
        int         n;
        logic [7:0] q;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) put_sel(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    put_sel(pst_pkg::CH_DOT);
                    n = pick_len();
                    repeat (n) put_sel(seg_char(1'b0));
                end
                4, 5: begin
                    put_sel(pst_pkg::CH_LBR);
                    if ($urandom_range(0, 3) == 0)
                        put_sel(pst_pkg::CH_SPACE);
                    if ($urandom_range(0, 2) == 0)
                        put_sel(pst_pkg::CH_MINUS);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
                    repeat (n) put_sel(8'($urandom_range(pst_pkg::CH_ZERO, pst_pkg::CH_NINE)));
                    if ($urandom_range(0, 7) == 0) begin
                        put_sel(pst_pkg::CH_MINUS);
                        put_sel(8'($urandom_range(pst_pkg::CH_ZERO, pst_pkg::CH_NINE)));
                    end
                    if ($urandom_range(0, 3) == 0)
                        put_sel(pst_pkg::CH_TAB);
                    put_sel(pst_pkg::CH_RBR);
                end
                6, 7: begin
                    put_sel(pst_pkg::CH_LBR);
                    if ($urandom_range(0, 4) == 0)
                        put_sel(pst_pkg::CH_SPACE);
                    q = $urandom_range(0, 1) ? pst_pkg::CH_DQ : pst_pkg::CH_SQ;
                    put_sel(q);
                    n = pick_len();
                    repeat (n) put_sel(seg_char(1'b1));
                    if ($urandom_range(0, 7) != 0)
                        put_sel(($urandom_range(0, 7) == 0) ?
                                (q == pst_pkg::CH_DQ ? pst_pkg::CH_SQ : pst_pkg::CH_DQ) : q);
                    put_sel(pst_pkg::CH_RBR);
                end
                8: begin
                    put_sel(pst_pkg::CH_LBR);
                    n = pick_len();
                    repeat (n) put_sel(seg_char(1'b1));
                    put_sel(pst_pkg::CH_RBR);
                end
                default: begin
                    n = $urandom_range(1, 3);
                    repeat (n) put_sel($urandom_range(0, 1) ? pst_pkg::CH_RBR : seg_char(1'b0));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            put_sel(pst_pkg::CH_LBR);
            n = $urandom_range(0, 5);
            repeat (n) put_sel(seg_char(1'b1));
        end
        put_sel(pst_pkg::CH_NUL);
    endtask

    initial begin
        int n_sel;
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_str(".");
        send_char(8'hFF);
        send_str("[-2147483648][\" k\"]]");
        send_char(pst_pkg::CH_NUL);
        send_str("[9");
        send_char(pst_pkg::CH_NUL);
        drain();

        n_sel = 0;
        while (sb.n_chars < CHAR_TARGET) begin
            build_selector();
            while (sel_q.size() != 0)
                send_char(sel_q.pop_front());
            n_sel++;
            if (n_sel % 6 == 0)
                drain();
        end

        drain();
        repeat (80) @(negedge aclk);
        if (sb.token_q.size() != 0)
            sb.report($sformatf("%0d expected items never arrived", sb.token_q.size()));
        $display("sent %0d characters (%0d not ignored) in %0d random selectors",
                 sb.n_chars, sb.n_busy, n_sel);
        $display("checked %0d key chars, %0d indices, %0d end markers, %0d truncated; %0d errors",
                 sb.n_keys, sb.n_idx, sb.n_end, sb.n_trunc, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
